// ----- hdl/psn_pkg.sv -----
package psn_pkg;

  // Default sizes
  localparam int MAX_WIRES_DEF       = 16;
  localparam int MAX_COMPARATORS_DEF = 64;
  localparam int VALUE_BITS_DEF      = 32;

  // Register reset value
  localparam logic [4:0] WIRE_COUNT_RESET = 5'd16;

  // Request modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  // One request
  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         stage_position;
    logic [3:0]         first_wire;
    logic [3:0]         second_wire;
    logic signed [31:0] data_value;
  } cmd_t;

  // One result
  typedef struct packed {
    logic signed [31:0] out_value;
    logic [3:0]         out_wire;
    logic               last_value;
    logic               rejected;
  } result_t;

  // Comparator table entry
  typedef struct packed {
    logic [7:0] position;
    logic [3:0] first;
    logic [3:0] second;
  } comp_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_READ,
    ST_INS_CHECK,
    ST_EV_READ,
    ST_EV_WIRES,
    ST_EV_CMP,
    ST_EV_SWAP2,
    ST_EMIT
  } state_t;

endpackage

// ----- hdl/psn_ram.sv -----
module psn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/programmable_sorting_network.sv -----
// Run-time loadable comparator network over signed values. Requests are taken
// when start is high and busy is low; results come out on result with done
// high for exactly one cycle and cannot be stalled. A clear or a load that
// does not complete a vector leaves busy low. Adding a comparator keeps the
// table sorted by position (ties in arrival order): each stored entry with a
// larger position is read and moved up one slot, then the new entry is
// written into the slot left free (slot 0 when the table is empty). A
// refused comparator gives one result with rejected set, in the cycle after
// the request.
// The load that completes a vector walks the comparator table in order with
// a read-compare-write on the wire memory, skipping a comparator that names a
// wire outside the current wire count; a swap writes the two wires one at a
// time (the wire memory has one write port). Then the wire count values
// stream out one per cycle; the last result appears in the cycle busy falls.
module programmable_sorting_network #(
  parameter int MAX_WIRES       = psn_pkg::MAX_WIRES_DEF,
  parameter int MAX_COMPARATORS = psn_pkg::MAX_COMPARATORS_DEF,
  parameter int VALUE_BITS      = psn_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  psn_pkg::cmd_t    cmd,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata,
  output logic             done,
  output psn_pkg::result_t result
);

  localparam int AW = (MAX_COMPARATORS > 1) ? $clog2(MAX_COMPARATORS) : 1;
  localparam int CW = $clog2(MAX_COMPARATORS + 1);
  localparam int WW = $clog2(MAX_WIRES);
  localparam int VW = $clog2(MAX_WIRES + 1);
  localparam int EW = $bits(psn_pkg::comp_entry_t);

  psn_pkg::state_t      state, state_next;
  logic [CW-1:0]        count;
  logic [VW-1:0]        loaded;
  logic [4:0]           wire_count;
  psn_pkg::comp_entry_t new_q;
  psn_pkg::comp_entry_t cmp_q;
  logic [AW-1:0]        ins_idx;
  logic [CW-1:0]        k;
  logic [VALUE_BITS-1:0] a_hold;
  logic [WW-1:0]        e;
  logic                 emit_d;
  logic [WW-1:0]        idx_d;
  logic                 last_d;
  logic                 rej_q;

  // Memory ports
  logic                  tbl_we;
  logic [AW-1:0]         tbl_waddr, tbl_raddr;
  psn_pkg::comp_entry_t  tbl_wdata, tbl_rd;
  logic [EW-1:0]         tbl_rdata;
  logic                  wv_we;
  logic [WW-1:0]         wv_waddr, wv_raddr_a, wv_raddr_b;
  logic [VALUE_BITS-1:0] wv_wdata, rd_a, rd_b;

  logic          accept, bad, vec_done, last_cmp, skip, greater, shift, e_last;
  logic [VW-1:0] wires_eff, load_inc;

  psn_ram #(.WIDTH(EW), .DEPTH(MAX_COMPARATORS)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  // Two copies of the wire values, written together, read at two addresses
  psn_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIRES)) u_wires_a (
    .clk(clk), .we(wv_we), .waddr(wv_waddr), .wdata(wv_wdata),
    .raddr(wv_raddr_a), .rdata(rd_a)
  );

  psn_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIRES)) u_wires_b (
    .clk(clk), .we(wv_we), .waddr(wv_waddr), .wdata(wv_wdata),
    .raddr(wv_raddr_b), .rdata(rd_b)
  );

  assign tbl_rd = psn_pkg::comp_entry_t'(tbl_rdata);

  // Effective wire count, clamped to 2..MAX_WIRES
  always_comb begin
    if (wire_count < 5'd2) begin
      wires_eff = VW'(2);
    end else if (int'(wire_count) > MAX_WIRES) begin
      wires_eff = VW'(MAX_WIRES);
    end else begin
      wires_eff = VW'(wire_count);
    end
  end

  // Request decode and loop conditions
  assign busy     = (state != psn_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign bad      = (int'(cmd.first_wire) >= int'(wires_eff)) ||
                    (int'(cmd.second_wire) >= int'(wires_eff)) ||
                    (int'(count) >= MAX_COMPARATORS);
  assign load_inc = loaded + VW'(1);
  assign vec_done = (load_inc >= wires_eff);
  assign last_cmp = ((k + CW'(1)) == count);
  assign skip     = (int'(tbl_rd.first) >= int'(wires_eff)) ||
                    (int'(tbl_rd.second) >= int'(wires_eff));
  assign greater  = ($signed(rd_a) > $signed(rd_b));
  assign shift    = (tbl_rd.position > new_q.position);
  assign e_last   = ((VW'(e) + VW'(1)) == wires_eff);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      psn_pkg::ST_IDLE: begin
        if (accept && cmd.mode == psn_pkg::MODE_ADD && !bad) begin
          state_next = psn_pkg::ST_INS_READ;
        end else if (accept && cmd.mode == psn_pkg::MODE_LOAD && vec_done) begin
          state_next = (count == '0) ? psn_pkg::ST_EMIT : psn_pkg::ST_EV_READ;
        end
      end
      psn_pkg::ST_INS_READ: begin
        state_next = (ins_idx == '0) ? psn_pkg::ST_IDLE : psn_pkg::ST_INS_CHECK;
      end
      psn_pkg::ST_INS_CHECK: begin
        state_next = shift ? psn_pkg::ST_INS_READ : psn_pkg::ST_IDLE;
      end
      psn_pkg::ST_EV_READ: begin
        state_next = psn_pkg::ST_EV_WIRES;
      end
      psn_pkg::ST_EV_WIRES: begin
        if (skip) begin
          state_next = last_cmp ? psn_pkg::ST_EMIT : psn_pkg::ST_EV_READ;
        end else begin
          state_next = psn_pkg::ST_EV_CMP;
        end
      end
      psn_pkg::ST_EV_CMP: begin
        if (greater) begin
          state_next = psn_pkg::ST_EV_SWAP2;
        end else begin
          state_next = last_cmp ? psn_pkg::ST_EMIT : psn_pkg::ST_EV_READ;
        end
      end
      psn_pkg::ST_EV_SWAP2: begin
        state_next = last_cmp ? psn_pkg::ST_EMIT : psn_pkg::ST_EV_READ;
      end
      psn_pkg::ST_EMIT: begin
        state_next = e_last ? psn_pkg::ST_IDLE : psn_pkg::ST_EMIT;
      end
      default: state_next = psn_pkg::ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    tbl_we     = 1'b0;
    tbl_waddr  = ins_idx;
    tbl_wdata  = new_q;
    tbl_raddr  = k[AW-1:0];
    wv_we      = 1'b0;
    wv_waddr   = WW'(loaded);
    wv_wdata   = VALUE_BITS'(cmd.data_value);
    wv_raddr_a = WW'(tbl_rd.first);
    wv_raddr_b = WW'(tbl_rd.second);
    unique case (state)
      psn_pkg::ST_IDLE: begin
        wv_we = accept && (cmd.mode == psn_pkg::MODE_LOAD);
      end
      psn_pkg::ST_INS_READ: begin
        tbl_raddr = ins_idx - AW'(1);
        tbl_we    = (ins_idx == '0);
      end
      psn_pkg::ST_INS_CHECK: begin
        tbl_we    = 1'b1;
        tbl_wdata = shift ? tbl_rd : new_q;
      end
      psn_pkg::ST_EV_READ, psn_pkg::ST_EV_WIRES: begin
      end
      psn_pkg::ST_EV_CMP: begin
        wv_we    = greater;
        wv_waddr = WW'(cmp_q.first);
        wv_wdata = rd_b;
      end
      psn_pkg::ST_EV_SWAP2: begin
        wv_we    = 1'b1;
        wv_waddr = WW'(cmp_q.second);
        wv_wdata = a_hold;
      end
      psn_pkg::ST_EMIT: begin
        wv_raddr_a = e;
      end
      default: begin
      end
    endcase
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= psn_pkg::ST_IDLE;
      count      <= '0;
      loaded     <= '0;
      wire_count <= psn_pkg::WIRE_COUNT_RESET;
      k          <= '0;
      e          <= '0;
      emit_d     <= 1'b0;
      rej_q      <= 1'b0;
    end else begin
      state  <= state_next;
      rej_q  <= accept && (cmd.mode == psn_pkg::MODE_ADD) && bad;
      emit_d <= (state == psn_pkg::ST_EMIT);
      idx_d  <= e;
      last_d <= e_last;
      e      <= (state == psn_pkg::ST_EMIT && !e_last) ? e + WW'(1) : '0;
      if (cfg_we) begin
        wire_count <= cfg_wdata;
      end
      unique case (state)
        psn_pkg::ST_IDLE: begin
          if (accept) begin
            unique case (cmd.mode)
              psn_pkg::MODE_CLEAR: count <= '0;
              psn_pkg::MODE_ADD: begin
                new_q   <= '{position: cmd.stage_position, first: cmd.first_wire,
                             second: cmd.second_wire};
                ins_idx <= AW'(count);
              end
              psn_pkg::MODE_LOAD: begin
                loaded <= vec_done ? '0 : load_inc;
                k      <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        psn_pkg::ST_INS_READ: begin
          if (ins_idx == '0) begin
            count <= count + CW'(1);
          end
        end
        psn_pkg::ST_INS_CHECK: begin
          if (shift) begin
            ins_idx <= ins_idx - AW'(1);
          end else begin
            count <= count + CW'(1);
          end
        end
        psn_pkg::ST_EV_READ: begin
        end
        psn_pkg::ST_EV_WIRES: begin
          cmp_q <= tbl_rd;
          if (skip) begin
            k <= k + CW'(1);
          end
        end
        psn_pkg::ST_EV_CMP: begin
          a_hold <= rd_a;
          if (!greater) begin
            k <= k + CW'(1);
          end
        end
        psn_pkg::ST_EV_SWAP2: begin
          k <= k + CW'(1);
        end
        psn_pkg::ST_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result port
  always_comb begin
    result.out_value  = emit_d ? 32'(rd_a) : '0;
    result.out_wire   = emit_d ? 4'(idx_d) : '0;
    result.last_value = emit_d && last_d;
    result.rejected   = rej_q;
  end
  assign done = emit_d || rej_q;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_COMPARATORS)
    else $error("comparator count beyond table size");

  a_loaded_range: assert property (@(posedge clk) disable iff (rst)
    int'(loaded) < MAX_WIRES)
    else $error("load count beyond wire memory");

  a_reject_cause: assert property (@(posedge clk) disable iff (rst)
    rej_q |-> $past(start && !busy && cmd.mode == psn_pkg::MODE_ADD))
    else $error("reject without add request");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(emit_d && rej_q))
    else $error("data result and reject in same cycle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit_d && last_d) |=> !emit_d)
    else $error("data result after last of vector");

endmodule

// ----- verif/programmable_sorting_network_test.sv -----
module programmable_sorting_network_test;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  psn_pkg::cmd_t cmd = '0;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic done;
  psn_pkg::result_t result;

  programmable_sorting_network i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .result    (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Shadow of the network state
  logic [7:0] comp_pos [psn_pkg::MAX_COMPARATORS_DEF];
  logic [3:0] comp_first [psn_pkg::MAX_COMPARATORS_DEF];
  logic [3:0] comp_second [psn_pkg::MAX_COMPARATORS_DEF];
  int comp_count = 0;
  logic signed [31:0] wire_vals [psn_pkg::MAX_WIRES_DEF];
  int vals_loaded = 0;
  logic [4:0] wire_cfg = psn_pkg::WIRE_COUNT_RESET;

  psn_pkg::cmd_t pending_requests[$];
  psn_pkg::result_t expected_results[$];
  psn_pkg::result_t next_expected;
  int requests_queued = 0;
  int requests_taken = 0;
  int error_count = 0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic int eff_wires(logic [4:0] cfg);
    if (cfg < 2) return 2;
    if (cfg > psn_pkg::MAX_WIRES_DEF) return psn_pkg::MAX_WIRES_DEF;
    return int'(cfg);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Update the shadow state for one accepted request and queue its results
  task automatic predict_request(psn_pkg::cmd_t c);
    int wires;
    int p;
    int k;
    logic signed [31:0] a;
    logic signed [31:0] b;
    psn_pkg::result_t r;
    wires = eff_wires(wire_cfg);
    case (c.mode)
      psn_pkg::MODE_CLEAR: begin
        comp_count = 0;
      end
      psn_pkg::MODE_ADD: begin
        if (c.first_wire >= wires || c.second_wire >= wires ||
            comp_count >= psn_pkg::MAX_COMPARATORS_DEF) begin
          r = '0;
          r.rejected = 1'b1;
          expected_results.push_back(r);
        end else begin
          comp_pos[comp_count] = c.stage_position;
          comp_first[comp_count] = c.first_wire;
          comp_second[comp_count] = c.second_wire;
          comp_count++;
        end
      end
      psn_pkg::MODE_LOAD: begin
        if (vals_loaded < psn_pkg::MAX_WIRES_DEF) wire_vals[vals_loaded] = c.data_value;
        vals_loaded++;
        if (vals_loaded >= wires) begin
          vals_loaded = 0;
          // ascending position, ties in insertion order; stale wires skipped
          for (p = 0; p < 256; p++) begin
            for (k = 0; k < comp_count; k++) begin
              if (comp_pos[k] == p && comp_first[k] < wires && comp_second[k] < wires) begin
                a = wire_vals[comp_first[k]];
                b = wire_vals[comp_second[k]];
                if (a > b) begin
                  wire_vals[comp_first[k]] = b;
                  wire_vals[comp_second[k]] = a;
                end
              end
            end
          end
          for (k = 0; k < wires; k++) begin
            r = '0;
            r.out_value = wire_vals[k];
            r.out_wire = k[3:0];
            r.last_value = (k == wires - 1);
            expected_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_request(cmd);
        requests_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cmd <= pending_requests.pop_front();
          start <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = 60;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results in order against the expected ones
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result, '0);
      end else begin
        next_expected = expected_results.pop_front();
        if (result.out_value !== next_expected.out_value)
          report_mismatch("out_value", result.out_value, next_expected.out_value);
        if (result.out_wire !== next_expected.out_wire)
          report_mismatch("out_wire", result.out_wire, next_expected.out_wire);
        if (result.last_value !== next_expected.last_value)
          report_mismatch("last_value", result.last_value, next_expected.last_value);
        if (result.rejected !== next_expected.rejected)
          report_mismatch("rejected", result.rejected, next_expected.rejected);
      end
    end
  end

  // Watchdog on cycles with neither a request nor a result
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("programmable_sorting_network regression: fail");
    $finish;
  end

  function automatic psn_pkg::cmd_t random_cmd(logic [1:0] mode);
    logic [63:0] bits;
    psn_pkg::cmd_t c;
    bits = {$urandom, $urandom};
    c = bits[$bits(psn_pkg::cmd_t)-1:0];
    c.mode = mode;
    return c;
  endfunction

  function automatic psn_pkg::cmd_t add_cmd(logic [7:0] pos, logic [3:0] fw,
                                            logic [3:0] sw);
    psn_pkg::cmd_t c;
    c = random_cmd(psn_pkg::MODE_ADD);
    c.stage_position = pos;
    c.first_wire = fw;
    c.second_wire = sw;
    return c;
  endfunction

  function automatic psn_pkg::cmd_t load_cmd(logic signed [31:0] v);
    psn_pkg::cmd_t c;
    c = random_cmd(psn_pkg::MODE_LOAD);
    c.data_value = v;
    return c;
  endfunction

  // Mostly in-range comparators, small positions often to force ties
  function automatic psn_pkg::cmd_t random_add(int wires);
    psn_pkg::cmd_t c;
    c = random_cmd(psn_pkg::MODE_ADD);
    if ($urandom_range(0, 1) == 0) c.stage_position = $urandom_range(0, 3);
    if ($urandom_range(0, 9) != 0) begin
      c.first_wire = $urandom_range(0, wires - 1);
      c.second_wire = $urandom_range(0, wires - 1);
    end
    return c;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3: return -1;
      4, 5: return int'($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(psn_pkg::cmd_t c);
    pending_requests.push_back(c);
    requests_queued++;
  endtask

  // Wait until the block has taken everything and gone quiet
  task automatic drain();
    while (requests_taken != requests_queued || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Network programs followed by vectors, with some noise mixed in
  task automatic gen_phase(int budget, bit fill_table);
    int wires;
    int made;
    int n_adds;
    bit first_prog;
    wires = eff_wires(wire_cfg);
    made = 0;
    first_prog = 1'b1;
    while (made < budget) begin
      if (first_prog || $urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, first_prog ? 1 : 4) != 0) begin
          queue_req(random_cmd(psn_pkg::MODE_CLEAR));
          made++;
        end
        // enough adds to overflow the table even with some refused
        n_adds = (fill_table && first_prog) ? psn_pkg::MAX_COMPARATORS_DEF + 12 :
                 $urandom_range(1, 12);
        repeat (n_adds) begin
          queue_req(random_add(wires));
          made++;
        end
        first_prog = 1'b0;
      end
      repeat ($urandom_range(1, 2) * wires) begin
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 2))
            0: queue_req(random_cmd(MODE_UNUSED));
            1: begin
              queue_req(random_add(wires));
              made++;
            end
            default: begin
              queue_req(random_cmd(psn_pkg::MODE_CLEAR));
              made++;
            end
          endcase
        end
        queue_req(load_cmd(pick_value()));
        made++;
      end
    end
    // leave a partial vector behind for the next wire count
    repeat ($urandom_range(0, wires - 1)) queue_req(load_cmd(pick_value()));
  endtask

  initial begin : stimulus
    int wire_settings [9] = '{2, 0, 31, 1, 7, 17, 16, 13, 3};
    psn_pkg::cmd_t c;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored mode, clear, field extremes, equal wires, position ties
    c = '1;
    queue_req(c);
    queue_req(random_cmd(psn_pkg::MODE_CLEAR));
    queue_req(add_cmd(8'd255, 4'd15, 4'd0));
    queue_req(add_cmd(8'd0, 4'd0, 4'd15));
    queue_req(add_cmd(8'd0, 4'd7, 4'd7));
    queue_req(add_cmd(8'd0, 4'd0, 4'd15));
    queue_req(add_cmd(8'd128, 4'd3, 4'd12));
    queue_req(add_cmd(8'd0, 4'd1, 4'd2));
    queue_req(load_cmd(32'sh8000_0000));
    queue_req(load_cmd(32'sh7fff_ffff));
    queue_req(load_cmd(0));
    queue_req(load_cmd(-1));
    repeat (12) queue_req(load_cmd(pick_value()));
    drain();

    // Random phases over a range of wire counts, extremes included
    foreach (wire_settings[i]) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= wire_settings[i][4:0];
      wire_cfg = wire_settings[i][4:0];
      @(posedge clk);
      cfg_we <= 1'b0;
      gen_phase(25, i == 0);
      drain();
    end

    if (error_count == 0) begin
      $display("programmable_sorting_network regression: pass");
    end else begin
      $display("programmable_sorting_network regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/psn_pkg.sv
hdl/psn_ram.sv
hdl/programmable_sorting_network.sv
verif/programmable_sorting_network_test.sv
